### rtl/core/rvsm_pkg.sv
// Shared types and constants for the retriggered voice sample mixer.
`default_nettype none

package rvsm_pkg;

	localparam int CHAN_W   = 12;
	localparam int ADDR_W   = 20;
	localparam int LENGTH_W = 21;
	localparam int SAMPLE_W = 16;

	typedef enum logic [1:0] {
		CMD_TRIGGER = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRIG,
		ST_TICK
	} back_state_t;

	typedef struct packed {
		logic [1:0]                 command;
		logic [CHAN_W-1:0]          event_channel;
		logic [ADDR_W-1:0]          event_start;
		logic [LENGTH_W-1:0]        event_length;
		logic                       source_ended;
		logic [ADDR_W-1:0]          memory_address;
		logic signed [SAMPLE_W-1:0] memory_left;
		logic signed [SAMPLE_W-1:0] memory_right;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_left;
		logic signed [SAMPLE_W-1:0] mix_right;
		logic                       finished;
	} out_t;

	// Classified command as it waits between front and back
	typedef struct packed {
		cmd_t                    op;
		logic [CHAN_W-1:0]       chan;
		logic [ADDR_W-1:0]       addr;
		logic [LENGTH_W-1:0]     length;
		logic                    ended;
		logic [2*SAMPLE_W-1:0]   word;
	} job_t;

endpackage

`default_nettype wire

### rtl/core/rvsm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rvsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/rvsm_fifo.sv
// Small generic FIFO used for the command and result queues.
`default_nettype none

module rvsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### rtl/core/rvsm_front.sv
// Front end: takes input transactions, classifies them and queues them for the back end.
`default_nettype none

module rvsm_front #(
	parameter int SAMPLE_ADDR_BITS = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rvsm_pkg::in_t item,
	output logic               full,
	output logic               job_valid,
	output rvsm_pkg::job_t     job,
	input  wire logic          job_pop
);

	localparam int LIM_W = (SAMPLE_ADDR_BITS + 1 > rvsm_pkg::LENGTH_W) ?
		SAMPLE_ADDR_BITS + 1 : rvsm_pkg::LENGTH_W;
	localparam logic [LIM_W-1:0] LEN_LIMIT = LIM_W'(1) << SAMPLE_ADDR_BITS;

	rvsm_pkg::job_t job_in;
	logic           job_empty;

	always_comb begin
		job_in.op     = rvsm_pkg::cmd_t'(item.command);
		job_in.chan   = item.event_channel;
		job_in.addr   = (job_in.op == rvsm_pkg::CMD_WRITE) ? item.memory_address :
			item.event_start;
		// lengths past the end of sample memory are clipped to its size
		if (LIM_W'(item.event_length) > LEN_LIMIT) begin
			job_in.length = LEN_LIMIT[rvsm_pkg::LENGTH_W-1:0];
		end else begin
			job_in.length = item.event_length;
		end
		job_in.ended  = item.source_ended;
		job_in.word   = {item.memory_right, item.memory_left};
	end

	rvsm_fifo #(
		.WIDTH ($bits(rvsm_pkg::job_t)),
		.DEPTH (4)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job),
		.empty  (job_empty)
	);

	assign job_valid = !job_empty;

endmodule

`default_nettype wire

### rtl/core/rvsm_back.sv
// Back end: voice table walker, sample memory and mix accumulator.
`default_nettype none

module rvsm_back #(
	parameter int VOICES           = 32,
	parameter int SAMPLE_ADDR_BITS = 20,
	parameter int CHANNEL_BITS     = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire rvsm_pkg::job_t job,
	output logic                job_pop,
	output logic                res_push,
	output rvsm_pkg::out_t      res_data,
	input  wire logic           res_full
);

	localparam int SAB     = SAMPLE_ADDR_BITS;
	localparam int CB      = CHANNEL_BITS;
	localparam int IDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W   = $clog2(VOICES + 1);
	localparam int LEN_W   = SAB + 1;
	localparam int ENTRY_W = CB + SAB + LEN_W + SAB;
	localparam int ACC_W   = rvsm_pkg::SAMPLE_W + 1 + IDX_W;
	localparam int WORD_W  = 2 * rvsm_pkg::SAMPLE_W;
	localparam logic [IDX_W-1:0]        LAST   = IDX_W'(VOICES - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

	rvsm_pkg::back_state_t state_q, state_d;

	rvsm_pkg::job_t           job_q;
	logic [VOICES-1:0]        voice_active_q;
	logic [CNT_W-1:0]         rd_idx_q;
	logic                     valid_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic                     valid_s2;
	logic                     act_s2;
	logic                     last_s2;
	logic                     end_s3;
	logic signed [ACC_W-1:0]  acc_l_q;
	logic signed [ACC_W-1:0]  acc_r_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_idx_q;

	// voice table
	logic                     tab_we;
	logic [IDX_W-1:0]         tab_waddr;
	logic [ENTRY_W-1:0]       tab_wdata;
	logic [ENTRY_W-1:0]       tab_rdata;
	logic [CB-1:0]            e_chan;
	logic [SAB-1:0]           e_start;
	logic [LEN_W-1:0]         e_len;
	logic [SAB-1:0]           e_pos;
	logic [LEN_W-1:0]         pos_inc;

	// sample memory
	logic                     smp_we;
	logic [SAB-1:0]           smp_raddr;
	logic [WORD_W-1:0]        smp_rdata;

	logic                     issue;
	logic                     start_walk;
	logic                     clear_all;
	logic                     set_active;
	logic [IDX_W-1:0]         set_idx;
	logic                     clr_active;
	logic                     act_s1;
	logic                     trig_s1;
	logic                     tick_s1;
	logic                     match;
	logic                     trig_last;
	logic                     have_free;
	logic [IDX_W-1:0]         free_now;
	logic [LEN_W-1:0]         len_v;
	logic signed [rvsm_pkg::SAMPLE_W-1:0] sat_l;
	logic signed [rvsm_pkg::SAMPLE_W-1:0] sat_r;

	assign e_pos   = tab_rdata[SAB-1:0];
	assign e_len   = tab_rdata[SAB +: LEN_W];
	assign e_start = tab_rdata[SAB + LEN_W +: SAB];
	assign e_chan  = tab_rdata[2 * SAB + LEN_W +: CB];
	assign pos_inc = LEN_W'(e_pos) + 1'b1;
	assign len_v   = LEN_W'(job_q.length);

	assign act_s1    = valid_s1 && voice_active_q[idx_s1];
	assign trig_s1   = (state_q == rvsm_pkg::ST_TRIG) && valid_s1;
	assign tick_s1   = (state_q == rvsm_pkg::ST_TICK) && valid_s1;
	assign match     = trig_s1 && act_s1 && (e_chan == CB'(job_q.chan));
	assign trig_last = trig_s1 && (idx_s1 == LAST);
	assign have_free = free_found_q || !voice_active_q[idx_s1];
	assign free_now  = free_found_q ? free_idx_q : idx_s1;
	assign smp_raddr = e_start + e_pos;

	always_comb begin
		if (acc_l_q > SAT_HI) begin
			sat_l = SAT_HI[rvsm_pkg::SAMPLE_W-1:0];
		end else if (acc_l_q < SAT_LO) begin
			sat_l = SAT_LO[rvsm_pkg::SAMPLE_W-1:0];
		end else begin
			sat_l = acc_l_q[rvsm_pkg::SAMPLE_W-1:0];
		end
		if (acc_r_q > SAT_HI) begin
			sat_r = SAT_HI[rvsm_pkg::SAMPLE_W-1:0];
		end else if (acc_r_q < SAT_LO) begin
			sat_r = SAT_LO[rvsm_pkg::SAMPLE_W-1:0];
		end else begin
			sat_r = acc_r_q[rvsm_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		job_pop    = 1'b0;
		smp_we     = 1'b0;
		clear_all  = 1'b0;
		start_walk = 1'b0;
		issue      = 1'b0;
		res_push   = 1'b0;
		res_data   = '0;
		tab_we     = 1'b0;
		tab_waddr  = idx_s1;
		tab_wdata  = {e_chan, e_start, e_len, e_pos};
		set_active = 1'b0;
		set_idx    = free_now;
		clr_active = 1'b0;

		case (state_q)
			rvsm_pkg::ST_IDLE: begin
				if (job_valid) begin
					case (job.op)
						rvsm_pkg::CMD_WRITE: begin
							job_pop = 1'b1;
							smp_we  = 1'b1;
						end
						rvsm_pkg::CMD_CLEAR: begin
							job_pop   = 1'b1;
							clear_all = 1'b1;
						end
						rvsm_pkg::CMD_TRIGGER: begin
							job_pop    = 1'b1;
							start_walk = 1'b1;
							state_d    = rvsm_pkg::ST_TRIG;
						end
						rvsm_pkg::CMD_TICK: begin
							// a result slot is held free for the whole tick
							if (!res_full) begin
								job_pop = 1'b1;
								if (job.ended && !(|voice_active_q)) begin
									res_push          = 1'b1;
									res_data.finished = 1'b1;
								end else begin
									start_walk = 1'b1;
									state_d    = rvsm_pkg::ST_TICK;
								end
							end
						end
						default: begin
							job_pop = 1'b1;
						end
					endcase
				end
			end
			rvsm_pkg::ST_TRIG: begin
				issue = (rd_idx_q != CNT_W'(VOICES)) && !match && !trig_last;
				if (match) begin
					// retrigger: restart at the top, keep the old sound
					tab_we    = 1'b1;
					tab_wdata = {e_chan, e_start, e_len, SAB'(0)};
					state_d   = rvsm_pkg::ST_IDLE;
				end else if (trig_last) begin
					if ((len_v != '0) && have_free) begin
						tab_we     = 1'b1;
						tab_waddr  = free_now;
						tab_wdata  = {CB'(job_q.chan), SAB'(job_q.addr), len_v, SAB'(0)};
						set_active = 1'b1;
					end
					state_d = rvsm_pkg::ST_IDLE;
				end
			end
			rvsm_pkg::ST_TICK: begin
				issue = (rd_idx_q != CNT_W'(VOICES));
				if (tick_s1 && act_s1) begin
					tab_we     = 1'b1;
					tab_wdata  = {e_chan, e_start, e_len, pos_inc[SAB-1:0]};
					clr_active = (pos_inc >= e_len);
				end
				if (end_s3) begin
					res_push           = 1'b1;
					res_data.mix_left  = sat_l;
					res_data.mix_right = sat_r;
					state_d            = rvsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rvsm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_active_q <= '0;
			rd_idx_q       <= '0;
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			end_s3         <= 1'b0;
			free_found_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= tick_s1;
			end_s3   <= valid_s2 && last_s2;
			if (start_walk) begin
				rd_idx_q     <= '0;
				free_found_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (trig_s1 && !voice_active_q[idx_s1]) begin
					free_found_q <= 1'b1;
				end
			end
			if (clear_all) begin
				voice_active_q <= '0;
			end else if (set_active) begin
				voice_active_q[set_idx] <= 1'b1;
			end else if (clr_active) begin
				voice_active_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		idx_s1  <= rd_idx_q[IDX_W-1:0];
		act_s2  <= act_s1;
		last_s2 <= (idx_s1 == LAST);
		if (trig_s1 && !free_found_q && !voice_active_q[idx_s1]) begin
			free_idx_q <= idx_s1;
		end
		if (start_walk) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (valid_s2 && act_s2) begin
			acc_l_q <= acc_l_q + ACC_W'($signed(smp_rdata[rvsm_pkg::SAMPLE_W-1:0]));
			acc_r_q <= acc_r_q + ACC_W'($signed(smp_rdata[WORD_W-1:rvsm_pkg::SAMPLE_W]));
		end
	end

	rvsm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (VOICES)
	) u_voice_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (tab_rdata)
	);

	rvsm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (1 << SAB)
	) u_sample_mem (
		.clk   (clk),
		.we    (smp_we),
		.waddr (SAB'(job.addr)),
		.wdata (job.word),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

endmodule

`default_nettype wire

### rtl/core/retriggered_voice_sample_mixer.sv
// Commands pass through the command queue; the back end then does a memory write or clear
// in its idle state, walks the voice table for a trigger or a tick, or reports a finished tick without a walk.
// Throughput: one transaction at a time in the back end, bound by the walk of the voice
// table (one voice a cycle through its read port).
// Reset clears the queues and all voice active bits; voice table and sample memory keep
// their contents, which are undefined until written.
`default_nettype none

module retriggered_voice_sample_mixer #(
	parameter int VOICES           = 32,
	parameter int SAMPLE_ADDR_BITS = 20,
	parameter int CHANNEL_BITS     = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire rvsm_pkg::in_t item,
	output logic               empty,
	input  wire logic          pop,
	output rvsm_pkg::out_t     result
);

	logic           job_valid;
	logic           job_pop;
	rvsm_pkg::job_t job;
	logic           res_push;
	logic           res_full;
	rvsm_pkg::out_t res_data;

	rvsm_front #(
		.SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	rvsm_back #(
		.VOICES           (VOICES),
		.SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
		.CHANNEL_BITS     (CHANNEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	rvsm_fifo #(
		.WIDTH ($bits(rvsm_pkg::out_t)),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_job_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("back end took a command from an empty queue");

	a_finished_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.finished) |->
		(res_data.mix_left == 16'sd0 && res_data.mix_right == 16'sd0))
		else $error("finished result carries a non-zero mix");

endmodule

`default_nettype wire
